@@ hdl/lca_pkg.sv @@
package lca_pkg;

    // Fixed field widths of the stream payload.
    localparam int NODE_IN_W = 10;
    localparam int TIME_W    = 11;
    localparam int OUT_W     = 10;

    // Bit offsets of the fields inside the input tdata.
    localparam int OFS_NODE   = 0;
    localparam int OFS_PARENT = 10;
    localparam int OFS_ENTER  = 20;
    localparam int OFS_LEAVE  = 31;
    localparam int OFS_OTHER  = 42;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] leave;
        logic [TIME_W-1:0] enter;
    } t_times;

    localparam int TIMES_W = $bits(t_times);

    typedef enum logic [3:0] {
        S_IDLE,
        S_W1,
        S_W2,
        S_BR,
        S_LD0,
        S_LDR,
        S_LDW,
        S_QA,
        S_QT,
        S_UP,
        S_CMP,
        S_RES,
        S_OUT
    } t_state;

    // Node that addresses the jump-table read port.
    typedef enum logic [1:0] {
        JN_MID,
        JN_A,
        JN_NEXT
    } t_jnode;

    // Node that addresses the time-table read port.
    typedef enum logic [1:0] {
        TN_A,
        TN_B,
        TN_UP
    } t_tnode;

    typedef enum logic [1:0] {
        RS_A,
        RS_B,
        RS_JT
    } t_rsel;

    typedef struct packed {
        logic   in_ready;
        logic   tm_we;
        logic   tm_re;
        t_tnode tm_rsel;
        logic   jt_we;
        logic   jt_wsrc_rd;
        logic   jt_re;
        t_jnode jt_rsel;
        logic   cap_tb;
        logic   cur_init;
        logic   cur_step;
        logic   mid_par;
        logic   mid_rd;
        logic   up_load;
        logic   res_load;
        t_rsel  res_sel;
        logic   out_load;
    } t_ctrl;

    typedef struct packed {
        logic is_query;
        logic cov_fwd;
        logic cov_rev;
        logic out_free;
    } t_stat;

    // True when x is an ancestor of y, or the same node, by the DFS times.
    function automatic logic covers(t_times x, t_times y);
        return (x.enter <= y.enter) && (x.leave >= y.leave);
    endfunction

endpackage

@@ hdl/lca_ram.sv @@
module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lca_wrap.sv @@
module lca_wrap #(
    parameter int NODES = 1024,
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [lca_pkg::NODE_IN_W-1:0]  i_node_a,
    input  logic [lca_pkg::NODE_IN_W-1:0]  i_node_b,
    input  logic [lca_pkg::NODE_IN_W-1:0]  i_node_p,
    output logic [NODE_W-1:0]              o_node_a,
    output logic [NODE_W-1:0]              o_node_b,
    output logic [NODE_W-1:0]              o_node_p
);

    localparam int IN_W  = lca_pkg::NODE_IN_W;
    localparam int LANES = 3;

    logic [IN_W-1:0]   r_x   [LANES];
    logic [IN_W-1:0]   r_q   [LANES];
    logic [NODE_W-1:0] r_rem [LANES];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x[0] <= i_node_a;
            r_x[1] <= i_node_b;
            r_x[2] <= i_node_p;
        end
    end

    // The captured indices pass through r_q into r_rem, whichever branch is built.
    generate
        if (NODES >= (1 << IN_W)) begin : g_pass
            always_ff @(posedge i_clk) begin
                for (int i = 0; i < LANES; i++) begin
                    r_q[i]   <= r_x[i];
                    r_rem[i] <= NODE_W'(r_q[i]);
                end
            end
        end else begin : g_div
            // Quotient by a scaled reciprocal; exact for every input below 2^IN_W.
            localparam int K     = IN_W + NODE_W;
            localparam int PW    = K + IN_W;
            localparam int RECIP = (1 << K) / NODES + 1;

            logic [PW-1:0]   w_prod [LANES];
            logic [IN_W-1:0] w_rem  [LANES];

            always_comb begin
                for (int i = 0; i < LANES; i++) begin
                    w_prod[i] = PW'(r_x[i]) * PW'(RECIP);
                    w_rem[i]  = r_x[i] - IN_W'(r_q[i] * IN_W'(NODES));
                end
            end

            always_ff @(posedge i_clk) begin
                for (int i = 0; i < LANES; i++) begin
                    r_q[i]   <= w_prod[i][PW-1 -: IN_W];
                    r_rem[i] <= w_rem[i][NODE_W-1:0];
                end
            end
        end
    endgenerate

    assign o_node_a = r_rem[0];
    assign o_node_b = r_rem[1];
    assign o_node_p = r_rem[2];

endmodule

@@ hdl/lca_ctrl.sv @@
module lca_ctrl #(
    parameter int LEVELS = 10,
    localparam int LV_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  lca_pkg::t_stat     i_stat,
    output lca_pkg::t_ctrl     o_ctrl,
    output logic [LV_W-1:0]    o_rd_lv,
    output logic [LV_W-1:0]    o_wr_lv
);

    lca_pkg::t_state r_state;
    lca_pkg::t_state n_state;
    logic [LV_W-1:0] r_lv;
    logic [LV_W-1:0] n_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lca_pkg::S_IDLE;
            r_lv    <= '0;
        end else begin
            r_state <= n_state;
            r_lv    <= n_lv;
        end
    end

    always_comb begin
        n_state = r_state;
        n_lv    = r_lv;
        o_ctrl  = '0;
        o_rd_lv = '0;
        o_wr_lv = '0;
        case (r_state)
            lca_pkg::S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_accept) begin
                    n_state = lca_pkg::S_W1;
                end
            end
            lca_pkg::S_W1: begin
                n_state = lca_pkg::S_W2;
            end
            lca_pkg::S_W2: begin
                n_state = lca_pkg::S_BR;
            end
            lca_pkg::S_BR: begin
                if (i_stat.is_query) begin
                    o_ctrl.tm_re   = 1'b1;
                    o_ctrl.tm_rsel = lca_pkg::TN_B;
                    n_state        = lca_pkg::S_QA;
                end else begin
                    n_state = lca_pkg::S_LD0;
                end
            end
            lca_pkg::S_LD0: begin
                o_ctrl.tm_we   = 1'b1;
                o_ctrl.jt_we   = 1'b1;
                o_ctrl.mid_par = 1'b1;
                n_lv           = LV_W'(1);
                if (LEVELS == 1) begin
                    n_state = lca_pkg::S_IDLE;
                end else begin
                    n_state = lca_pkg::S_LDR;
                end
            end
            lca_pkg::S_LDR: begin
                // The ancestor one level down is read from its own row.
                o_ctrl.jt_re   = 1'b1;
                o_ctrl.jt_rsel = lca_pkg::JN_MID;
                o_rd_lv        = r_lv - LV_W'(1);
                n_state        = lca_pkg::S_LDW;
            end
            lca_pkg::S_LDW: begin
                o_ctrl.jt_we      = 1'b1;
                o_ctrl.jt_wsrc_rd = 1'b1;
                o_ctrl.mid_rd     = 1'b1;
                o_wr_lv           = r_lv;
                if (r_lv == LV_W'(LEVELS - 1)) begin
                    n_state = lca_pkg::S_IDLE;
                end else begin
                    n_lv    = r_lv + LV_W'(1);
                    n_state = lca_pkg::S_LDR;
                end
            end
            lca_pkg::S_QA: begin
                o_ctrl.cap_tb  = 1'b1;
                o_ctrl.tm_re   = 1'b1;
                o_ctrl.tm_rsel = lca_pkg::TN_A;
                n_state        = lca_pkg::S_QT;
            end
            lca_pkg::S_QT: begin
                if (i_stat.cov_fwd) begin
                    o_ctrl.res_load = 1'b1;
                    o_ctrl.res_sel  = lca_pkg::RS_A;
                    n_state         = lca_pkg::S_OUT;
                end else if (i_stat.cov_rev) begin
                    o_ctrl.res_load = 1'b1;
                    o_ctrl.res_sel  = lca_pkg::RS_B;
                    n_state         = lca_pkg::S_OUT;
                end else begin
                    o_ctrl.cur_init = 1'b1;
                    o_ctrl.jt_re    = 1'b1;
                    o_ctrl.jt_rsel  = lca_pkg::JN_A;
                    o_rd_lv         = LV_W'(LEVELS - 1);
                    n_lv            = LV_W'(LEVELS - 1);
                    n_state         = lca_pkg::S_UP;
                end
            end
            lca_pkg::S_UP: begin
                o_ctrl.up_load = 1'b1;
                o_ctrl.tm_re   = 1'b1;
                o_ctrl.tm_rsel = lca_pkg::TN_UP;
                n_state        = lca_pkg::S_CMP;
            end
            lca_pkg::S_CMP: begin
                // Take the jump unless it lands on an ancestor of the second node,
                // and start the read for the next level from wherever we end up.
                o_ctrl.cur_step = 1'b1;
                o_ctrl.jt_re    = 1'b1;
                o_ctrl.jt_rsel  = lca_pkg::JN_NEXT;
                if (r_lv == '0) begin
                    o_rd_lv = '0;
                    n_state = lca_pkg::S_RES;
                end else begin
                    o_rd_lv = r_lv - LV_W'(1);
                    n_lv    = r_lv - LV_W'(1);
                    n_state = lca_pkg::S_UP;
                end
            end
            lca_pkg::S_RES: begin
                o_ctrl.res_load = 1'b1;
                o_ctrl.res_sel  = lca_pkg::RS_JT;
                n_state         = lca_pkg::S_OUT;
            end
            lca_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = lca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lca_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/lca_binary_lifting.sv @@
// Lowest-common-ancestor engine with a binary-lifting jump table.
// Input beats carry a kind bit in tuser: a load beat gives one node, its parent
// and its DFS entry and exit times; a query beat gives two nodes. Only queries
// produce an output beat, holding their lowest common ancestor.
// Nodes are loaded parent before child, and the root names itself as parent.
// Node indices at or above NODES wrap modulo NODES.
// One item is in work at a time; tready is high only while the engine is idle.
// A load steps through capture, the branch and the level-0 write, then reads and
// writes the jump table once per further level, a chain of dependent reads,
// before the next beat can be taken.
// A query whose one node covers the other is settled by that check alone;
// otherwise the descending jump search reads and then compares at each level
// from the top down. Either way the result goes to the output register and the
// engine returns to idle.
// The result sits in an output register: while the receiver stalls, the engine
// still takes the next beat and works on it, and holds a new result until the
// register is free. Reset empties the output and returns to idle; the tables
// are not cleared, so a node must be loaded before any item refers to it.
module lca_binary_lifting #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // node[9:0], parent_node[19:10], enter_time[30:20], leave_time[41:31],
    // other_node[51:42], zero fill[55:52]
    input  logic [lca_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // req_type[0]
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // ancestor_node[9:0], zero fill[15:10]
    output logic [lca_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    localparam int NODE_W    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LV_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JT_DEPTH  = NODES * LEVELS;
    localparam int JA_W      = $clog2(JT_DEPTH);
    localparam int IN_W      = lca_pkg::NODE_IN_W;
    localparam int TIME_W    = lca_pkg::TIME_W;

    lca_pkg::t_ctrl ctrl;
    lca_pkg::t_stat stat;
    logic [LV_W-1:0] rd_lv;
    logic [LV_W-1:0] wr_lv;

    logic s_accept;

    logic                r_req;
    logic [TIME_W-1:0]   r_enter;
    logic [TIME_W-1:0]   r_leave;
    lca_pkg::t_times     r_tb;
    logic [NODE_W-1:0]   r_cur;
    logic [NODE_W-1:0]   r_up;
    logic [NODE_W-1:0]   r_mid;
    logic [NODE_W-1:0]   r_res;
    logic                r_ovalid;
    logic [lca_pkg::OUT_W-1:0] r_odata;

    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [NODE_W-1:0]   node_p;
    logic [NODE_W-1:0]   nxt;
    logic [NODE_W-1:0]   jt_node;
    logic [NODE_W-1:0]   tm_node;
    logic [NODE_W-1:0]   res_node;

    logic [JA_W-1:0]     jt_waddr;
    logic [JA_W-1:0]     jt_raddr;
    logic [NODE_W-1:0]   jt_wdata;
    logic [NODE_W-1:0]   jt_rdata;
    lca_pkg::t_times     tm_wdata;
    lca_pkg::t_times     tm_rdata;

    assign o_s_tready = ctrl.in_ready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req   <= i_s_tuser;
            r_enter <= i_s_tdata[lca_pkg::OFS_ENTER +: TIME_W];
            r_leave <= i_s_tdata[lca_pkg::OFS_LEAVE +: TIME_W];
        end
    end

    lca_wrap #(
        .NODES (NODES)
    ) u_wrap (
        .i_clk    (i_clk),
        .i_load   (s_accept),
        .i_node_a (i_s_tdata[lca_pkg::OFS_NODE +: IN_W]),
        .i_node_b (i_s_tdata[lca_pkg::OFS_OTHER +: IN_W]),
        .i_node_p (i_s_tdata[lca_pkg::OFS_PARENT +: IN_W]),
        .o_node_a (node_a),
        .o_node_b (node_b),
        .o_node_p (node_p)
    );

    lca_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .o_rd_lv  (rd_lv),
        .o_wr_lv  (wr_lv)
    );

    always_comb begin
        stat.is_query = (r_req == lca_pkg::REQ_QUERY);
        stat.cov_fwd  = lca_pkg::covers(tm_rdata, r_tb);
        stat.cov_rev  = lca_pkg::covers(r_tb, tm_rdata);
        stat.out_free = !r_ovalid || i_m_tready;
    end

    assign nxt = stat.cov_fwd ? r_cur : r_up;

    always_comb begin
        case (ctrl.jt_rsel)
            lca_pkg::JN_MID:  jt_node = r_mid;
            lca_pkg::JN_A:    jt_node = node_a;
            lca_pkg::JN_NEXT: jt_node = nxt;
            default:          jt_node = node_a;
        endcase
        case (ctrl.tm_rsel)
            lca_pkg::TN_A:  tm_node = node_a;
            lca_pkg::TN_B:  tm_node = node_b;
            lca_pkg::TN_UP: tm_node = jt_rdata;
            default:        tm_node = node_a;
        endcase
        case (ctrl.res_sel)
            lca_pkg::RS_A:  res_node = node_a;
            lca_pkg::RS_B:  res_node = node_b;
            lca_pkg::RS_JT: res_node = jt_rdata;
            default:        res_node = node_a;
        endcase
    end

    // Row-major jump table: one row of LEVELS ancestors per node.
    assign jt_raddr = JA_W'(JA_W'(jt_node) * JA_W'(LEVELS)) + JA_W'(rd_lv);
    assign jt_waddr = JA_W'(JA_W'(node_a) * JA_W'(LEVELS)) + JA_W'(wr_lv);
    assign jt_wdata = ctrl.jt_wsrc_rd ? jt_rdata : node_p;

    assign tm_wdata.enter = r_enter;
    assign tm_wdata.leave = r_leave;

    lca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (JT_DEPTH)
    ) u_jump_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.jt_we),
        .i_waddr (jt_waddr),
        .i_wdata (jt_wdata),
        .i_re    (ctrl.jt_re),
        .i_raddr (jt_raddr),
        .o_rdata (jt_rdata)
    );

    lca_ram #(
        .WIDTH (lca_pkg::TIMES_W),
        .DEPTH (NODES)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.tm_we),
        .i_waddr (node_a),
        .i_wdata (tm_wdata),
        .i_re    (ctrl.tm_re),
        .i_raddr (tm_node),
        .o_rdata (tm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (ctrl.cap_tb) begin
            r_tb <= tm_rdata;
        end
        if (ctrl.cur_init) begin
            r_cur <= node_a;
        end else if (ctrl.cur_step) begin
            r_cur <= nxt;
        end
        if (ctrl.up_load) begin
            r_up <= jt_rdata;
        end
        if (ctrl.mid_par) begin
            r_mid <= node_p;
        end else if (ctrl.mid_rd) begin
            r_mid <= jt_rdata;
        end
        if (ctrl.res_load) begin
            r_res <= res_node;
        end
        if (ctrl.out_load) begin
            r_odata <= lca_pkg::OUT_W'(r_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = lca_pkg::OUT_DATA_W'(r_odata);

endmodule

@@ hdl/lca_checker.sv @@
module lca_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [lca_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    logic s_accept;

    assign s_accept = i_s_tvalid && o_s_tready;

    // A stalled output beat keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat changed while stalled");

    // The engine is busy in the cycle after taking a beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("input accepted on back-to-back cycles");

    // A load never creates a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (i_s_tuser == lca_pkg::REQ_LOAD) |=> !$rose(o_m_tvalid))
        else $error("result appeared after a load");

    // Only the node index is driven; the fill bits stay zero.
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[lca_pkg::OUT_DATA_W-1:lca_pkg::OUT_W] == '0)
        else $error("output fill bits not zero");

endmodule

bind lca_binary_lifting lca_checker u_lca_checker (.*);
